// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk in scope; all but ASSERT_RESET also expect arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLY(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed: implication");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

// Implication that is also checked around reset.
`define ASSERT_RESET(label, a, b) \
	label: assert property (@(posedge clk) (a) |-> (b)) \
		else $error("assertion failed: reset behavior");

`endif

// ===== src/ssd_pkg.sv =====
// Shared widths, constants and types for the segment distance block.
// No dependencies.
package ssd_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int T_FRAC_BITS     = 16;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int LEN_W   = PROD_W;
	localparam int DOT_W   = PROD_W + 1;
	localparam int T_W     = T_FRAC_BITS + 1;
	localparam int SCALE_W = T_W + 1 + DIFF_W;
	localparam int EX_W    = COORD_W + 3;
	localparam int SQ_W    = 2 * EX_W;
	localparam int ROOT_W  = EX_W;
	localparam int REM_W   = ROOT_W + 3;
	localparam int DIST_W  = 18;

	localparam int T_HALF = 1 << (T_FRAC_BITS - 1);
	localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int OQ_DEPTH  = 4;
	localparam int OQPTR_W   = $clog2(OQ_DEPTH);
	localparam int OQCNT_W   = $clog2(OQ_DEPTH + 1);

	localparam int LANE_LAT = 4 + T_FRAC_BITS + 5;
	localparam int BACK_LAT = LANE_LAT + 1 + ROOT_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax0;
		logic signed [COORD_W-1:0] ay0;
		logic signed [COORD_W-1:0] ax1;
		logic signed [COORD_W-1:0] ay1;
		logic signed [COORD_W-1:0] bx0;
		logic signed [COORD_W-1:0] by0;
		logic signed [COORD_W-1:0] bx1;
		logic signed [COORD_W-1:0] by1;
	} seg_pair_t;

	typedef struct packed {
		seg_pair_t seg;
		logic      hit;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== src/ssd_queue.sv =====
// Small flop queue between the classify front and the distance back end.
// Depends on ssd_pkg.
module ssd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ssd_pkg::item_t   wdata,
	input  logic             pop,
	output ssd_pkg::item_t   rdata,
	output ssd_pkg::q_stat_t stat
);

	ssd_pkg::item_t                  mem_q [ssd_pkg::QDEPTH];
	logic [ssd_pkg::QPTR_W-1:0]      wptr_q;
	logic [ssd_pkg::QPTR_W-1:0]      rptr_q;
	logic [ssd_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign stat.full  = (cnt_q == ssd_pkg::QCNT_W'(ssd_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== src/ssd_front.sv =====
// Front end: cross products and bounding boxes, decides the crossing flag.
// Depends on ssd_pkg.
module ssd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  ssd_pkg::seg_pair_t seg,
	output logic               out_vld,
	output ssd_pkg::item_t     out_item
);

	typedef struct packed {
		logic signed [ssd_pkg::DIFF_W-1:0] eax, eay, ebx, eby;
		logic signed [ssd_pkg::DIFF_W-1:0] w1x, w1y, w2x, w2y;
		logic signed [ssd_pkg::DIFF_W-1:0] w3x, w3y, w4x, w4y;
	} diffs_t;

	typedef struct packed {
		logic signed [ssd_pkg::PROD_W-1:0] p1a, p1b, p2a, p2b;
		logic signed [ssd_pkg::PROD_W-1:0] p3a, p3b, p4a, p4b;
	} prods_t;

	logic               v_s1, v_s2, v_s3;
	ssd_pkg::seg_pair_t seg_s1, seg_s2, seg_s3;
	diffs_t             d_s1;
	prods_t             p_s2;
	logic               la_s1, lb_s1, box_s1;
	logic               la_s2, lb_s2, box_s2;
	logic               hit_s3;

	diffs_t d_in;
	logic   box_in;
	logic signed [ssd_pkg::COORD_W-1:0] mnax, mxax, mnay, mxay, mnbx, mxbx, mnby, mxby;
	logic signed [ssd_pkg::DOT_W-1:0]   c1, c2, c3, c4;
	logic                               col, st12, st34, hit_in;

	always_comb begin
		d_in.eax = ssd_pkg::DIFF_W'(seg.ax1) - ssd_pkg::DIFF_W'(seg.ax0);
		d_in.eay = ssd_pkg::DIFF_W'(seg.ay1) - ssd_pkg::DIFF_W'(seg.ay0);
		d_in.ebx = ssd_pkg::DIFF_W'(seg.bx1) - ssd_pkg::DIFF_W'(seg.bx0);
		d_in.eby = ssd_pkg::DIFF_W'(seg.by1) - ssd_pkg::DIFF_W'(seg.by0);
		d_in.w1x = ssd_pkg::DIFF_W'(seg.bx0) - ssd_pkg::DIFF_W'(seg.ax0);
		d_in.w1y = ssd_pkg::DIFF_W'(seg.by0) - ssd_pkg::DIFF_W'(seg.ay0);
		d_in.w2x = ssd_pkg::DIFF_W'(seg.bx1) - ssd_pkg::DIFF_W'(seg.ax0);
		d_in.w2y = ssd_pkg::DIFF_W'(seg.by1) - ssd_pkg::DIFF_W'(seg.ay0);
		d_in.w3x = ssd_pkg::DIFF_W'(seg.ax0) - ssd_pkg::DIFF_W'(seg.bx0);
		d_in.w3y = ssd_pkg::DIFF_W'(seg.ay0) - ssd_pkg::DIFF_W'(seg.by0);
		d_in.w4x = ssd_pkg::DIFF_W'(seg.ax1) - ssd_pkg::DIFF_W'(seg.bx0);
		d_in.w4y = ssd_pkg::DIFF_W'(seg.ay1) - ssd_pkg::DIFF_W'(seg.by0);
		mnax = (seg.ax0 < seg.ax1) ? seg.ax0 : seg.ax1;
		mxax = (seg.ax0 < seg.ax1) ? seg.ax1 : seg.ax0;
		mnay = (seg.ay0 < seg.ay1) ? seg.ay0 : seg.ay1;
		mxay = (seg.ay0 < seg.ay1) ? seg.ay1 : seg.ay0;
		mnbx = (seg.bx0 < seg.bx1) ? seg.bx0 : seg.bx1;
		mxbx = (seg.bx0 < seg.bx1) ? seg.bx1 : seg.bx0;
		mnby = (seg.by0 < seg.by1) ? seg.by0 : seg.by1;
		mxby = (seg.by0 < seg.by1) ? seg.by1 : seg.by0;
		box_in = (mnax <= mxbx) && (mnbx <= mxax) && (mnay <= mxby) && (mnby <= mxay);
	end

	// s2 -> s3: cross products and the crossing decision
	always_comb begin
		c1 = ssd_pkg::DOT_W'(p_s2.p1a) - ssd_pkg::DOT_W'(p_s2.p1b);
		c2 = ssd_pkg::DOT_W'(p_s2.p2a) - ssd_pkg::DOT_W'(p_s2.p2b);
		c3 = ssd_pkg::DOT_W'(p_s2.p3a) - ssd_pkg::DOT_W'(p_s2.p3b);
		c4 = ssd_pkg::DOT_W'(p_s2.p4a) - ssd_pkg::DOT_W'(p_s2.p4b);
		col  = (c1 == 0) && (c2 == 0) && (c3 == 0) && (c4 == 0);
		st12 = !(((c1 > 0) && (c2 > 0)) || ((c1 < 0) && (c2 < 0)));
		st34 = !(((c3 > 0) && (c4 > 0)) || ((c3 < 0) && (c4 < 0)));
		hit_in = la_s2 && lb_s2 && (col ? box_s2 : (st12 && st34));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= seg;
			d_s1   <= d_in;
			box_s1 <= box_in;
			la_s1  <= (seg.ax0 != seg.ax1) || (seg.ay0 != seg.ay1);
			lb_s1  <= (seg.bx0 != seg.bx1) || (seg.by0 != seg.by1);

			seg_s2 <= seg_s1;
			la_s2  <= la_s1;
			lb_s2  <= lb_s1;
			box_s2 <= box_s1;
			p_s2.p1a <= ssd_pkg::PROD_W'(d_s1.eax) * ssd_pkg::PROD_W'(d_s1.w1y);
			p_s2.p1b <= ssd_pkg::PROD_W'(d_s1.eay) * ssd_pkg::PROD_W'(d_s1.w1x);
			p_s2.p2a <= ssd_pkg::PROD_W'(d_s1.eax) * ssd_pkg::PROD_W'(d_s1.w2y);
			p_s2.p2b <= ssd_pkg::PROD_W'(d_s1.eay) * ssd_pkg::PROD_W'(d_s1.w2x);
			p_s2.p3a <= ssd_pkg::PROD_W'(d_s1.ebx) * ssd_pkg::PROD_W'(d_s1.w3y);
			p_s2.p3b <= ssd_pkg::PROD_W'(d_s1.eby) * ssd_pkg::PROD_W'(d_s1.w3x);
			p_s2.p4a <= ssd_pkg::PROD_W'(d_s1.ebx) * ssd_pkg::PROD_W'(d_s1.w4y);
			p_s2.p4b <= ssd_pkg::PROD_W'(d_s1.eby) * ssd_pkg::PROD_W'(d_s1.w4x);

			seg_s3 <= seg_s2;
			hit_s3 <= hit_in;
		end
	end

	assign out_vld      = v_s3;
	assign out_item.seg = seg_s3;
	assign out_item.hit = hit_s3;

endmodule

// ===== src/ssd_lane.sv =====
// One point-to-segment squared distance lane, fixed latency, shared stall.
// Depends on ssd_pkg.
module ssd_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ssd_pkg::COORD_W-1:0]  px,
	input  logic signed [ssd_pkg::COORD_W-1:0]  py,
	input  logic signed [ssd_pkg::COORD_W-1:0]  s0x,
	input  logic signed [ssd_pkg::COORD_W-1:0]  s0y,
	input  logic signed [ssd_pkg::COORD_W-1:0]  s1x,
	input  logic signed [ssd_pkg::COORD_W-1:0]  s1y,
	output logic        [ssd_pkg::SQ_W-1:0]     sq_dist
);

	localparam int DIV_STEPS = ssd_pkg::T_FRAC_BITS;

	typedef struct packed {
		logic        [ssd_pkg::LEN_W-1:0]   l2;
		logic signed [ssd_pkg::DIFF_W-1:0]  dx;
		logic signed [ssd_pkg::DIFF_W-1:0]  dy;
		logic signed [ssd_pkg::COORD_W-1:0] px;
		logic signed [ssd_pkg::COORD_W-1:0] py;
		logic signed [ssd_pkg::COORD_W-1:0] s0x;
		logic signed [ssd_pkg::COORD_W-1:0] s0y;
		logic                               zero;
		logic                               one;
	} ctx_t;

	logic signed [ssd_pkg::DIFF_W-1:0]  dx_s1, dy_s1, wx_s1, wy_s1;
	logic signed [ssd_pkg::COORD_W-1:0] px_s1, py_s1, s0x_s1, s0y_s1;
	logic        [ssd_pkg::PROD_W-1:0]  dxx_s2, dyy_s2;
	logic signed [ssd_pkg::PROD_W-1:0]  wdx_s2, wdy_s2;
	logic signed [ssd_pkg::DIFF_W-1:0]  dx_s2, dy_s2;
	logic signed [ssd_pkg::COORD_W-1:0] px_s2, py_s2, s0x_s2, s0y_s2;
	logic        [ssd_pkg::LEN_W-1:0]   l2_s3;
	logic signed [ssd_pkg::DOT_W-1:0]   dot_s3;
	logic signed [ssd_pkg::DIFF_W-1:0]  dx_s3, dy_s3;
	logic signed [ssd_pkg::COORD_W-1:0] px_s3, py_s3, s0x_s3, s0y_s3;
	ctx_t                               ctx_s4;
	logic        [ssd_pkg::LEN_W-1:0]   rem_s4;
	ctx_t                               dv_ctx_s5 [DIV_STEPS];
	logic        [ssd_pkg::LEN_W-1:0]   dv_rem_s5 [DIV_STEPS];
	logic        [DIV_STEPS-1:0]        dv_q_s5   [DIV_STEPS];
	ctx_t                               ctx_s6;
	logic        [ssd_pkg::T_W-1:0]     t_s6;
	ctx_t                               ctx_s7;
	logic signed [ssd_pkg::SCALE_W-1:0] prx_s7, pry_s7;
	logic signed [ssd_pkg::EX_W-1:0]    ex_s8, ey_s8;
	logic        [ssd_pkg::SQ_W-1:0]    exx_s9, eyy_s9;
	logic        [ssd_pkg::SQ_W-1:0]    sq_s10;

	logic signed [ssd_pkg::SCALE_W-1:0] rx, ry;
	logic        [DIV_STEPS-1:0]        q_last;
	ctx_t                               c_last;

	assign c_last = dv_ctx_s5[DIV_STEPS-1];
	assign q_last = dv_q_s5[DIV_STEPS-1];

	// rounded t*d back to coordinate units, halves upward (floor after bias)
	assign rx = (prx_s7 + $signed(ssd_pkg::SCALE_W'(ssd_pkg::T_HALF))) >>> ssd_pkg::T_FRAC_BITS;
	assign ry = (pry_s7 + $signed(ssd_pkg::SCALE_W'(ssd_pkg::T_HALF))) >>> ssd_pkg::T_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= ssd_pkg::DIFF_W'(s1x) - ssd_pkg::DIFF_W'(s0x);
			dy_s1  <= ssd_pkg::DIFF_W'(s1y) - ssd_pkg::DIFF_W'(s0y);
			wx_s1  <= ssd_pkg::DIFF_W'(px) - ssd_pkg::DIFF_W'(s0x);
			wy_s1  <= ssd_pkg::DIFF_W'(py) - ssd_pkg::DIFF_W'(s0y);
			px_s1  <= px;
			py_s1  <= py;
			s0x_s1 <= s0x;
			s0y_s1 <= s0y;

			dxx_s2 <= ssd_pkg::PROD_W'(dx_s1) * ssd_pkg::PROD_W'(dx_s1);
			dyy_s2 <= ssd_pkg::PROD_W'(dy_s1) * ssd_pkg::PROD_W'(dy_s1);
			wdx_s2 <= ssd_pkg::PROD_W'(wx_s1) * ssd_pkg::PROD_W'(dx_s1);
			wdy_s2 <= ssd_pkg::PROD_W'(wy_s1) * ssd_pkg::PROD_W'(dy_s1);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			s0x_s2 <= s0x_s1;
			s0y_s2 <= s0y_s1;

			l2_s3  <= dxx_s2 + dyy_s2;
			dot_s3 <= ssd_pkg::DOT_W'(wdx_s2) + ssd_pkg::DOT_W'(wdy_s2);
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			s0x_s3 <= s0x_s2;
			s0y_s3 <= s0y_s2;

			// clamp cases; a zero-length segment takes t = 0, i.e. its start point
			ctx_s4.l2   <= l2_s3;
			ctx_s4.dx   <= dx_s3;
			ctx_s4.dy   <= dy_s3;
			ctx_s4.px   <= px_s3;
			ctx_s4.py   <= py_s3;
			ctx_s4.s0x  <= s0x_s3;
			ctx_s4.s0y  <= s0y_s3;
			ctx_s4.zero <= (l2_s3 == '0) || (dot_s3 <= 0);
			ctx_s4.one  <= (l2_s3 != '0) && (dot_s3 > 0) &&
				(dot_s3 >= $signed({1'b0, l2_s3}));
			rem_s4      <= dot_s3[ssd_pkg::LEN_W-1:0];

			ctx_s6 <= c_last;
			if (c_last.one)
				t_s6 <= ssd_pkg::T_ONE;
			else if (c_last.zero)
				t_s6 <= '0;
			else
				t_s6 <= {1'b0, q_last};

			ctx_s7 <= ctx_s6;
			prx_s7 <= ssd_pkg::SCALE_W'($signed({1'b0, t_s6})) * ssd_pkg::SCALE_W'(ctx_s6.dx);
			pry_s7 <= ssd_pkg::SCALE_W'($signed({1'b0, t_s6})) * ssd_pkg::SCALE_W'(ctx_s6.dy);

			ex_s8 <= ssd_pkg::EX_W'(ctx_s7.px) - ssd_pkg::EX_W'(ctx_s7.s0x) -
				rx[ssd_pkg::EX_W-1:0];
			ey_s8 <= ssd_pkg::EX_W'(ctx_s7.py) - ssd_pkg::EX_W'(ctx_s7.s0y) -
				ry[ssd_pkg::EX_W-1:0];

			exx_s9 <= ssd_pkg::SQ_W'(ex_s8) * ssd_pkg::SQ_W'(ex_s8);
			eyy_s9 <= ssd_pkg::SQ_W'(ey_s8) * ssd_pkg::SQ_W'(ey_s8);

			sq_s10 <= exx_s9 + eyy_s9;
		end
	end

	// restoring divider, one quotient bit per stage: t = dot * 2^T / l2
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		ctx_t                       cin;
		logic [ssd_pkg::LEN_W-1:0]  rin;
		logic [DIV_STEPS-1:0]       qin;
		logic [ssd_pkg::LEN_W:0]    r2;
		logic                       ge;

		if (i == 0) begin : g_first
			assign cin = ctx_s4;
			assign rin = rem_s4;
			assign qin = '0;
		end else begin : g_next
			assign cin = dv_ctx_s5[i-1];
			assign rin = dv_rem_s5[i-1];
			assign qin = dv_q_s5[i-1];
		end

		assign r2 = {rin, 1'b0};
		assign ge = (r2 >= {1'b0, cin.l2});

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ctx_s5[i] <= cin;
				dv_rem_s5[i] <= ge ? (r2[ssd_pkg::LEN_W-1:0] - cin.l2) : r2[ssd_pkg::LEN_W-1:0];
				dv_q_s5[i]   <= {qin[DIV_STEPS-2:0], ge};
			end
		end
	end

	assign sq_dist = sq_s10;

endmodule

// ===== src/ssd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, shared stall.
// Depends on ssd_pkg.
module ssd_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ssd_pkg::SQ_W-1:0]      radicand,
	output logic [ssd_pkg::ROOT_W-1:0]    root
);

	localparam int STEPS = ssd_pkg::ROOT_W;

	logic [ssd_pkg::REM_W-1:0]  rem_s  [STEPS];
	logic [ssd_pkg::ROOT_W-1:0] root_s [STEPS];
	logic [ssd_pkg::SQ_W-1:0]   rad_s  [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [ssd_pkg::REM_W-1:0]  rin;
		logic [ssd_pkg::ROOT_W-1:0] qin;
		logic [ssd_pkg::SQ_W-1:0]   vin;
		logic [ssd_pkg::REM_W-1:0]  cur;
		logic [ssd_pkg::REM_W-1:0]  trial;
		logic                       ge;

		if (i == 0) begin : g_first
			assign rin = '0;
			assign qin = '0;
			assign vin = radicand;
		end else begin : g_next
			assign rin = rem_s[i-1];
			assign qin = root_s[i-1];
			assign vin = rad_s[i-1];
		end

		assign cur   = {rin[ssd_pkg::REM_W-3:0], vin[ssd_pkg::SQ_W-1 -: 2]};
		assign trial = ssd_pkg::REM_W'({qin, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (cur - trial) : cur;
				root_s[i] <= {qin[ssd_pkg::ROOT_W-2:0], ge};
				rad_s[i]  <= {vin[ssd_pkg::SQ_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[STEPS-1];

endmodule

// ===== src/segment_segment_distance.sv =====
// Top level of the segment-to-segment distance block.
// Depends on ssd_pkg, ssd_front, ssd_queue, ssd_lane and ssd_sqrt.

// Takes one pair of 2D segments (signed Q8.8 endpoints) per clock and returns,
// in order, the distance between them (unsigned, same fraction, floor of the
// exact root of the clamped squared distance) and a crossing flag; when the
// segments cross or touch the distance is zero. A zero-length segment never
// crosses and measures to its point. Sustained rate is one pair per cycle while
// results are popped: every part is fully pipelined and nothing iterates in
// place. From accept to result a pair passes the classification stages, the
// four-entry queue between front and back, then the back end (the distance
// lanes, set mainly by the 16-stage projection divider, the minimum register
// and the square root stages), then the result queue.
// Back pressure on pop stalls the back end as a whole once the four-entry
// result queue is full, and the front stalls only when its queue is full.
module segment_segment_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [ssd_pkg::COORD_W-1:0]  a_start_x,
	input  logic signed [ssd_pkg::COORD_W-1:0]  a_start_y,
	input  logic signed [ssd_pkg::COORD_W-1:0]  a_end_x,
	input  logic signed [ssd_pkg::COORD_W-1:0]  a_end_y,
	input  logic signed [ssd_pkg::COORD_W-1:0]  b_start_x,
	input  logic signed [ssd_pkg::COORD_W-1:0]  b_start_y,
	input  logic signed [ssd_pkg::COORD_W-1:0]  b_end_x,
	input  logic signed [ssd_pkg::COORD_W-1:0]  b_end_y,
	output logic                                empty,
	input  logic                                pop,
	output logic        [ssd_pkg::DIST_W-1:0]   seg_distance,
	output logic                                crossing
);

	// front side
	ssd_pkg::seg_pair_t seg_in;
	logic               fen;
	logic               fr_vld;
	ssd_pkg::item_t     fr_item;
	ssd_pkg::item_t     iq_head;
	ssd_pkg::q_stat_t   iq_stat;

	// back side
	logic                       en;
	logic                       iq_pop;
	logic [ssd_pkg::SQ_W-1:0]   lane_sq [4];
	logic [ssd_pkg::SQ_W-1:0]   m01, m23;
	logic [ssd_pkg::SQ_W-1:0]   min_s1;
	logic [ssd_pkg::ROOT_W-1:0] root;
	logic                       back_vld_s [ssd_pkg::BACK_LAT];
	logic                       back_hit_s [ssd_pkg::BACK_LAT];
	logic [ssd_pkg::DIST_W-1:0] res_dist;
	logic                       res_push;

	// result queue
	logic [ssd_pkg::DIST_W-1:0]   oq_dist_q  [ssd_pkg::OQ_DEPTH];
	logic                         oq_cross_q [ssd_pkg::OQ_DEPTH];
	logic [ssd_pkg::OQPTR_W-1:0]  oq_wptr_q, oq_rptr_q;
	logic [ssd_pkg::OQCNT_W-1:0]  oq_cnt_q;
	logic                         oq_full, oq_pop;

	assign seg_in.ax0 = a_start_x;
	assign seg_in.ay0 = a_start_y;
	assign seg_in.ax1 = a_end_x;
	assign seg_in.ay1 = a_end_y;
	assign seg_in.bx0 = b_start_x;
	assign seg_in.by0 = b_start_y;
	assign seg_in.bx1 = b_end_x;
	assign seg_in.by1 = b_end_y;

	// the front only moves when its last stage has a queue slot to land in
	assign fen  = !iq_stat.full;
	assign full = !fen;

	ssd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (fen),
		.in_vld   (push),
		.seg      (seg_in),
		.out_vld  (fr_vld),
		.out_item (fr_item)
	);

	ssd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_vld && fen),
		.wdata  (fr_item),
		.pop    (iq_pop),
		.rdata  (iq_head),
		.stat   (iq_stat)
	);

	// back end advances as one block while the result queue has room
	assign en     = !oq_full;
	assign iq_pop = en && !iq_stat.empty;

	// lanes: each endpoint of one segment against the other segment
	ssd_lane u_lane0 (
		.clk (clk), .en (en),
		.px  (iq_head.seg.ax0), .py (iq_head.seg.ay0),
		.s0x (iq_head.seg.bx0), .s0y (iq_head.seg.by0),
		.s1x (iq_head.seg.bx1), .s1y (iq_head.seg.by1),
		.sq_dist (lane_sq[0])
	);

	ssd_lane u_lane1 (
		.clk (clk), .en (en),
		.px  (iq_head.seg.ax1), .py (iq_head.seg.ay1),
		.s0x (iq_head.seg.bx0), .s0y (iq_head.seg.by0),
		.s1x (iq_head.seg.bx1), .s1y (iq_head.seg.by1),
		.sq_dist (lane_sq[1])
	);

	ssd_lane u_lane2 (
		.clk (clk), .en (en),
		.px  (iq_head.seg.bx0), .py (iq_head.seg.by0),
		.s0x (iq_head.seg.ax0), .s0y (iq_head.seg.ay0),
		.s1x (iq_head.seg.ax1), .s1y (iq_head.seg.ay1),
		.sq_dist (lane_sq[2])
	);

	ssd_lane u_lane3 (
		.clk (clk), .en (en),
		.px  (iq_head.seg.bx1), .py (iq_head.seg.by1),
		.s0x (iq_head.seg.ax0), .s0y (iq_head.seg.ay0),
		.s1x (iq_head.seg.ax1), .s1y (iq_head.seg.ay1),
		.sq_dist (lane_sq[3])
	);

	assign m01 = (lane_sq[1] < lane_sq[0]) ? lane_sq[1] : lane_sq[0];
	assign m23 = (lane_sq[3] < lane_sq[2]) ? lane_sq[3] : lane_sq[2];

	always_ff @(posedge clk) begin
		if (en)
			min_s1 <= (m23 < m01) ? m23 : m01;
	end

	ssd_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (min_s1),
		.root     (root)
	);

	// valid and crossing flag ride alongside the data path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssd_pkg::BACK_LAT; i++)
				back_vld_s[i] <= 1'b0;
		end else if (en) begin
			back_vld_s[0] <= !iq_stat.empty;
			for (int i = 1; i < ssd_pkg::BACK_LAT; i++)
				back_vld_s[i] <= back_vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			back_hit_s[0] <= iq_head.hit;
			for (int i = 1; i < ssd_pkg::BACK_LAT; i++)
				back_hit_s[i] <= back_hit_s[i-1];
		end
	end

	// saturate the root to the output width; crossing pairs report zero
	always_comb begin
		if (back_hit_s[ssd_pkg::BACK_LAT-1])
			res_dist = '0;
		else if (root[ssd_pkg::ROOT_W-1])
			res_dist = '1;
		else
			res_dist = root[ssd_pkg::DIST_W-1:0];
	end

	assign res_push = back_vld_s[ssd_pkg::BACK_LAT-1] && en;

	// result queue
	assign oq_full = (oq_cnt_q == ssd_pkg::OQCNT_W'(ssd_pkg::OQ_DEPTH));
	assign empty   = (oq_cnt_q == '0);
	assign oq_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wptr_q <= '0;
			oq_rptr_q <= '0;
			oq_cnt_q  <= '0;
		end else begin
			if (res_push)
				oq_wptr_q <= oq_wptr_q + 1'b1;
			if (oq_pop)
				oq_rptr_q <= oq_rptr_q + 1'b1;
			if (res_push && !oq_pop)
				oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (oq_pop && !res_push)
				oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_dist_q[oq_wptr_q]  <= res_dist;
			oq_cross_q[oq_wptr_q] <= back_hit_s[ssd_pkg::BACK_LAT-1];
		end
	end

	assign seg_distance = oq_dist_q[oq_rptr_q];
	assign crossing     = oq_cross_q[oq_rptr_q];

endmodule

// ===== src/ssd_checker.sv =====
// Port-level checks for the segment distance block, bound to the top level.
// Depends on assert_macros.svh and ssd_pkg.
`include "assert_macros.svh"

module ssd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                push,
	input logic                                full,
	input logic                                empty,
	input logic                                pop,
	input logic        [ssd_pkg::DIST_W-1:0]   seg_distance,
	input logic                                crossing
);

	// a crossing pair always reports zero distance
	`ASSERT_IMPLY(a_cross_zero, !empty && crossing, seg_distance == '0)

	// a waiting result is not withdrawn
	`ASSERT_NEXT(a_hold_valid, !empty && !pop, !empty)

	// a waiting result holds its value
	`ASSERT_NEXT(a_hold_data, !empty && !pop, $stable(seg_distance) && $stable(crossing))

	// coming out of reset nothing is queued and input is open
	`ASSERT_RESET(a_reset_state, !$past(arst_n), empty && !full)

endmodule

bind segment_segment_distance ssd_checker u_ssd_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for segment_segment_distance: computes the expected
// distance and crossing flag for every accepted segment pair and checks them.
// Depends on ssd_pkg and the RTL of segment_segment_distance.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int DRAIN_CYCLES    = 120;
	localparam int RANDOM_PAIRS    = 400;

	typedef struct packed {
		logic [DIST_W-1:0] dist_val;
		logic              cross_flag;
	} dist_result_t;

	// Reference distance calculator plus the in-order store of expected results.
	class distance_board;
		dist_result_t pending[$];
		int           errors;

		function new();
			errors = 0;
		endfunction

		static function int sgn(longint v);
			return int'(v > 0) - int'(v < 0);
		endfunction

		static function longint cross3(longint ox, longint oy, longint ex, longint ey,
			longint px, longint py);
			return (ex - ox) * (py - oy) - (ey - oy) * (px - ox);
		endfunction

		// Rounded t*v >> T_FRAC_BITS, halves toward +infinity.
		static function longint scale_by_t(longint t, longint v);
			longint prod;
			prod = t * v + (longint'(1) << (T_FRAC_BITS - 1));
			return prod >>> T_FRAC_BITS;
		endfunction

		static function longint point_seg_sq(longint px, longint py, longint s0x,
			longint s0y, longint s1x, longint s1y);
			longint dx, dy, len2, qx, qy, ex, ey, dot, t;
			dx = s1x - s0x;
			dy = s1y - s0y;
			len2 = dx * dx + dy * dy;
			qx = s0x;
			qy = s0y;
			if (len2 > 0) begin
				dot = (px - s0x) * dx + (py - s0y) * dy;
				if (dot <= 0)
					t = 0;
				else if (dot >= len2)
					t = longint'(1) << T_FRAC_BITS;
				else
					t = (dot << T_FRAC_BITS) / len2;
				qx = s0x + scale_by_t(t, dx);
				qy = s0y + scale_by_t(t, dy);
			end
			ex = px - qx;
			ey = py - qy;
			return ex * ex + ey * ey;
		endfunction

		static function longint int_sqrt(longint v);
			longint res, b;
			res = 0;
			b = longint'(1) << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// Note an accepted pair: work out and queue its expected result.
		function void note_request(seg_pair_t s);
			longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, c1, c2, c3, c4, m, d;
			bit hit;
			dist_result_t r;
			ax0 = longint'(s.ax0); ay0 = longint'(s.ay0);
			ax1 = longint'(s.ax1); ay1 = longint'(s.ay1);
			bx0 = longint'(s.bx0); by0 = longint'(s.by0);
			bx1 = longint'(s.bx1); by1 = longint'(s.by1);
			hit = 0;
			// zero-length segments never count as crossing
			if ((ax0 != ax1 || ay0 != ay1) && (bx0 != bx1 || by0 != by1)) begin
				c1 = cross3(ax0, ay0, ax1, ay1, bx0, by0);
				c2 = cross3(ax0, ay0, ax1, ay1, bx1, by1);
				c3 = cross3(bx0, by0, bx1, by1, ax0, ay0);
				c4 = cross3(bx0, by0, bx1, by1, ax1, ay1);
				if (c1 == 0 && c2 == 0 && c3 == 0 && c4 == 0) begin
					// collinear: bounding-box overlap decides
					hit = ((ax0 < ax1 ? ax0 : ax1) > (bx0 < bx1 ? bx0 : bx1) ?
						(ax0 < ax1 ? ax0 : ax1) : (bx0 < bx1 ? bx0 : bx1))
						<= ((ax0 > ax1 ? ax0 : ax1) < (bx0 > bx1 ? bx0 : bx1) ?
						(ax0 > ax1 ? ax0 : ax1) : (bx0 > bx1 ? bx0 : bx1))
						&& ((ay0 < ay1 ? ay0 : ay1) > (by0 < by1 ? by0 : by1) ?
						(ay0 < ay1 ? ay0 : ay1) : (by0 < by1 ? by0 : by1))
						<= ((ay0 > ay1 ? ay0 : ay1) < (by0 > by1 ? by0 : by1) ?
						(ay0 > ay1 ? ay0 : ay1) : (by0 > by1 ? by0 : by1));
				end else begin
					hit = (sgn(c1) * sgn(c2) <= 0) && (sgn(c3) * sgn(c4) <= 0);
				end
			end
			if (hit) begin
				r.dist_val = '0;
				r.cross_flag = 1'b1;
			end else begin
				m = point_seg_sq(ax0, ay0, bx0, by0, bx1, by1);
				d = point_seg_sq(ax1, ay1, bx0, by0, bx1, by1);
				if (d < m) m = d;
				d = point_seg_sq(bx0, by0, ax0, ay0, ax1, ay1);
				if (d < m) m = d;
				d = point_seg_sq(bx1, by1, ax0, ay0, ax1, ay1);
				if (d < m) m = d;
				d = int_sqrt(m);
				if (d > 262143) d = 262143;
				r.dist_val = d[DIST_W-1:0];
				r.cross_flag = 1'b0;
			end
			pending.push_back(r);
		endfunction

		// Compare a popped result against the oldest expectation.
		function void check_result(logic [DIST_W-1:0] got_dist, logic cross_flag);
			dist_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result dist=%0d crossing=%0b", $realtime, got_dist,
					cross_flag);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got_dist !== e.dist_val) begin
				$display("%0t: seg_distance expected %0d actual %0d", $realtime, e.dist_val,
					got_dist);
				errors++;
			end
			if (cross_flag !== e.cross_flag) begin
				$display("%0t: crossing expected %0b actual %0b", $realtime, e.cross_flag,
					cross_flag);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, push, pop, full, empty, crossing;
	logic signed [COORD_W-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
	logic signed [COORD_W-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
	logic [DIST_W-1:0] seg_distance;

	segment_segment_distance dut (.*);

	distance_board board;
	seg_pair_t     stim[$];
	int            idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random coordinate: half the time full range, else extremes or a small grid
	// so that touching, collinear and degenerate cases come up often.
	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(0, 8)) - 4) <<< 8;
		endcase
	endfunction

	function automatic seg_pair_t rand_pair();
		seg_pair_t s;
		int mode;
		mode = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 3) == 0 ? 1 : 2);
		s.ax0 = rand_coord(mode); s.ay0 = rand_coord(mode);
		s.ax1 = rand_coord(mode); s.ay1 = rand_coord(mode);
		s.bx0 = rand_coord(mode); s.by0 = rand_coord(mode);
		s.bx1 = rand_coord(mode); s.by1 = rand_coord(mode);
		// occasionally make a segment zero length or share an endpoint
		case ($urandom_range(0, 9))
			0: begin s.ax1 = s.ax0; s.ay1 = s.ay0; end
			1: begin s.bx1 = s.bx0; s.by1 = s.by0; end
			2: begin s.bx0 = s.ax1; s.by0 = s.ay1; end
			default: ;
		endcase
		return s;
	endfunction

	function automatic seg_pair_t mk(int ax0, int ay0, int ax1, int ay1,
		int bx0, int by0, int bx1, int by1);
		seg_pair_t s;
		s.ax0 = COORD_W'(ax0); s.ay0 = COORD_W'(ay0);
		s.ax1 = COORD_W'(ax1); s.ay1 = COORD_W'(ay1);
		s.bx0 = COORD_W'(bx0); s.by0 = COORD_W'(by0);
		s.bx1 = COORD_W'(bx1); s.by1 = COORD_W'(by1);
		return s;
	endfunction

	// Send one request, waiting out a random gap and any back pressure.
	// push stays high into the next request when the gap is zero.
	task automatic send_request(seg_pair_t s);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		{a_start_x, a_start_y, a_end_x, a_end_y} <= {s.ax0, s.ay0, s.ax1, s.ay1};
		{b_start_x, b_start_y, b_end_x, b_end_y} <= {s.bx0, s.by0, s.bx1, s.by1};
		do @(posedge clk); while (full);
		board.note_request(s);
	endtask

	// Result side: random stalls per result, popped at the clock edge.
	initial begin
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			board.check_result(seg_distance, crossing);
		end
	end

	// Watchdog: cycles with no request or result accepted.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		board = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		push = 1'b0;
		{a_start_x, a_start_y, a_end_x, a_end_y} = '0;
		{b_start_x, b_start_y, b_end_x, b_end_y} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: crossing, touching, collinear overlap/gap, zero length, extremes.
		stim.push_back(mk(-256, 0, 256, 0, 0, -256, 0, 256));
		stim.push_back(mk(0, 0, 256, 0, 256, 0, 512, 512));
		stim.push_back(mk(0, 0, 512, 0, 256, 0, 768, 0));
		stim.push_back(mk(0, 0, 256, 0, 512, 0, 768, 0));
		stim.push_back(mk(0, 0, 256, 256, 512, 512, 768, 768));
		stim.push_back(mk(100, 100, 100, 100, 0, 0, 512, 0));
		stim.push_back(mk(0, 0, 512, 0, 200, 0, 200, 0));
		stim.push_back(mk(7, 7, 7, 7, 7, 7, 7, 7));
		stim.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
		stim.push_back(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
		stim.push_back(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
		stim.push_back(mk(0, 0, 1000, 3, 10, 500, 20, 900));
		stim.push_back(mk(-1, -1, -1, 1, 1, -1, 1, 1));
		stim.push_back(mk(0, 0, 300, 0, 150, 1, 150, 400));
		stim.push_back(mk(32767, 0, -32768, 0, 0, 1, 0, 32767));
		stim.push_back(mk(-5000, 300, 4000, -700, 1234, -4321, -999, 8000));
		stim.push_back(mk(16'shffff, 16'sh5555, 16'shaaaa, 0, 16'sh5555, 16'shaaaa,
			16'sh7fff, 16'sh8000));
		foreach (stim[i])
			send_request(stim[i]);
		repeat (RANDOM_PAIRS)
			send_request(rand_pair());
		push <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
